### sv/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared widths, codes and record types of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int unsigned DefVoices    = 8;
  localparam int unsigned DefHeldNotes = 16;

  localparam int unsigned SpreadW = 14;
  localparam int unsigned BudgetW = 4;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned NoteW   = 7;
  localparam int unsigned TgtW    = 3;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned StateW  = 2;
  localparam int unsigned DetW    = 15;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = SpreadW;

  localparam logic [CfgIdxW-1:0] CfgSpread = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBudget = 1'd1;

  localparam logic [SpreadW-1:0] SpreadReset = '0;
  localparam logic [BudgetW-1:0] BudgetReset = 4'd8;

  typedef enum logic [ModeW-1:0] {
    ModeHeld   = 2'd0,
    ModeEmpty  = 2'd1,
    ModeFade   = 2'd2,
    ModeBudget = 2'd3
  } mode_e;

  typedef enum logic [StateW-1:0] {
    SlotInactive = 2'd0,
    SlotSustain  = 2'd1,
    SlotFading   = 2'd2
  } slot_state_e;

  // note and detune of one voice, as kept in the voice memory
  typedef struct packed {
    logic [NoteW-1:0] note;
    logic [DetW-1:0]  det;
  } vrec_t;

  // detune unit response
  typedef struct packed {
    logic                   done;
    logic signed [DetW-1:0] offset;
  } dt_rsp_t;

endpackage

### sv/pva_detune.sv
// ----------------------------------------------------------------------------
// pva_detune
// Symmetric detune offset for one sustaining voice: spread*(2i-d)/d with
// d = total-1, rounded to nearest, ties away from zero. A multiply state,
// then a restoring divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pva_detune
  import pva_pkg::*;
#(
  parameter int unsigned VOICES = DefVoices
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [$clog2(VOICES)-1:0]           rank_i,
  input  logic [$clog2(VOICES+1)-1:0]         total_i,
  input  logic [SpreadW-1:0]                  spread_i,
  output dt_rsp_t                             rsp_o
);

  localparam int unsigned VIW = $clog2(VOICES);
  localparam int unsigned CW  = $clog2(VOICES + 1);
  localparam int unsigned PW  = SpreadW + VIW;
  localparam int unsigned DW  = PW + 2;
  localparam int unsigned RMW = VIW + 2;
  localparam int unsigned SCW = $clog2(DW + 1);

  typedef enum logic [2:0] {
    DtIdle,
    DtMul,
    DtLoad,
    DtDiv,
    DtFin
  } dt_state_e;

  dt_state_e              st_q;
  logic                   neg_q;
  logic [VIW-1:0]         mag_q;
  logic [VIW-1:0]         d_q;
  logic [PW-1:0]          prod_q;
  logic [DW-1:0]          quo_q;
  logic [RMW-2:0]         rem_q;
  logic [SCW-1:0]         cnt_q;
  logic                   done_q;
  logic signed [DetW-1:0] res_q;

  logic signed [VIW+1:0]  diff;
  logic [VIW-1:0]         d_in;
  logic [RMW-1:0]         rem_sh;
  logic [RMW-1:0]         divisor;
  logic                   qbit;
  logic [DetW-1:0]        qmag;

  assign d_in    = VIW'(total_i - CW'(1));
  assign diff    = signed'({1'b0, rank_i, 1'b0}) - signed'({2'b00, d_in});
  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign divisor = {1'b0, d_q, 1'b0};
  assign qbit    = (rem_sh >= divisor);
  assign qmag    = DetW'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DtIdle;
      neg_q  <= 1'b0;
      mag_q  <= '0;
      d_q    <= '0;
      prod_q <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      res_q  <= '0;
    end else begin
      case (st_q)
        DtIdle: begin
          done_q <= start_i && (total_i <= CW'(1) || spread_i == '0);
          if (start_i) begin
            if (total_i <= CW'(1) || spread_i == '0) begin
              res_q <= '0;
            end else begin
              d_q   <= d_in;
              neg_q <= diff[VIW+1];
              mag_q <= diff[VIW+1] ? VIW'(-diff) : VIW'(diff);
              st_q  <= DtMul;
            end
          end
        end
        DtMul: begin
          prod_q <= PW'(spread_i) * PW'(mag_q);
          st_q   <= DtLoad;
        end
        DtLoad: begin
          // dividend 2*num + d, divisor 2*d
          quo_q <= {1'b0, prod_q, 1'b0} + DW'(d_q);
          rem_q <= '0;
          cnt_q <= SCW'(DW);
          st_q  <= DtDiv;
        end
        DtDiv: begin
          rem_q <= qbit ? (RMW-1)'(rem_sh - divisor) : rem_sh[RMW-2:0];
          quo_q <= {quo_q[DW-2:0], qbit};
          cnt_q <= cnt_q - SCW'(1);
          if (cnt_q == SCW'(1)) begin
            st_q <= DtFin;
          end
        end
        DtFin: begin
          res_q  <= neg_q ? -signed'(qmag) : signed'(qmag);
          done_q <= 1'b1;
          st_q   <= DtIdle;
        end
        default: begin
          done_q <= 1'b0;
          st_q   <= DtIdle;
        end
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.offset = res_q;

endmodule

### sv/polyphonic_voice_allocator.sv
// Held-note and fade-complete items are handled in the idle state; a budget check
// walks every voice in index order. An allocation run scans the voice memory
// twice per listed note and runs the bit-serial divider of the detune unit for
// each voice that was sustaining and whose note is still listed.
// Reset is asynchronous: voices inactive, list empty, registers at defaults.
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// Voice allocator with release stealing: per-voice note and detune live in a
// voice memory, the held list in a note memory, voice states in flops.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator
  import pva_pkg::*;
#(
  parameter int unsigned VOICES     = DefVoices,
  parameter int unsigned HELD_NOTES = DefHeldNotes
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ModeW-1:0]          mode_i,
  input  logic [NoteW-1:0]          note_i,
  input  logic                      last_note_i,
  input  logic [TgtW-1:0]           target_voice_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [SlotW-1:0]          voice_slot_o,
  output logic [StateW-1:0]         slot_state_o,
  output logic [NoteW-1:0]          slot_note_o,
  output logic signed [DetW-1:0]    detune_offset_o,
  output logic                      last_record_o
);

  localparam int unsigned VIW  = $clog2(VOICES);
  localparam int unsigned CW   = $clog2(VOICES + 1);
  localparam int unsigned HIW  = (HELD_NOTES > 1) ? $clog2(HELD_NOTES) : 1;
  localparam int unsigned HCW  = $clog2(HELD_NOTES + 1);
  localparam int unsigned CmpW = (CW > BudgetW) ? CW : BudgetW;

  typedef enum logic [3:0] {
    StIdle,
    StS1Hrd,
    StS1Scan,
    StS1Apply,
    StS3Hrd,
    StS3Scan,
    StS3Alloc,
    StEmRd,
    StEmChk,
    StEmDt,
    StEmOut,
    StBudget
  } ctl_state_e;

  // configuration
  logic [SpreadW-1:0] spread_q;
  logic [BudgetW-1:0] budget_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q <= SpreadReset;
      budget_q <= BudgetReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSpread: spread_q <= cfg_wdata_i;
        CfgBudget: budget_q <= cfg_wdata_i[BudgetW-1:0];
        default: ;
      endcase
    end
  end

  // voice memory
  vrec_t          vmem [VOICES];
  vrec_t          vmem_rdata_q;
  logic           vmem_re;
  logic [VIW-1:0] vmem_raddr;
  logic           vmem_we;
  logic [VIW-1:0] vmem_waddr;
  vrec_t          vmem_wdata;

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      vmem[vmem_waddr] <= vmem_wdata;
    end
    if (vmem_re) begin
      vmem_rdata_q <= vmem[vmem_raddr];
    end
  end

  // held-note memory
  logic [NoteW-1:0] hmem [HELD_NOTES];
  logic [NoteW-1:0] hmem_rdata_q;
  logic             hmem_re;
  logic             hmem_we;

  ctl_state_e          state_q;
  slot_state_e         slot_st_q [VOICES];
  logic [VOICES-1:0]   matched_q;
  logic [VOICES-1:0]   sus1_q;
  logic [HCW-1:0]      held_cnt_q;
  logic [HIW-1:0]      k_q;
  logic [VIW-1:0]      v_q;
  logic                iss_done_q;
  logic                pvld_q;
  logic [VIW-1:0]      pv_q;
  logic                found_q;
  logic                pick_i_vld_q;
  logic [VIW-1:0]      pick_i_q;
  logic                pick_f_vld_q;
  logic [VIW-1:0]      pick_f_q;
  logic [CW-1:0]       ncnt_q;
  logic [VIW-1:0]      rank_q;
  logic [CW-1:0]       act_cnt_q;
  logic [DetW-1:0]     det_q;
  logic                out_valid_q;
  logic [SlotW-1:0]    out_slot_q;
  logic [StateW-1:0]   out_state_q;
  logic [NoteW-1:0]    out_note_q;
  logic [DetW-1:0]     out_det_q;
  logic                out_last_q;

  always_ff @(posedge clk_i) begin
    if (hmem_we) begin
      hmem[held_cnt_q[HIW-1:0]] <= note_i;
    end
    if (hmem_re) begin
      hmem_rdata_q <= hmem[k_q];
    end
  end

  // detune unit
  dt_rsp_t dt_rsp;
  logic    dt_start;

  assign dt_start = (state_q == StEmChk) && sus1_q[v_q];

  pva_detune #(
    .VOICES(VOICES)
  ) u_detune (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dt_start),
    .rank_i  (rank_q),
    .total_i (ncnt_q),
    .spread_i(spread_q),
    .rsp_o   (dt_rsp)
  );

  logic accept;
  logic room;
  logic last_v;
  logic last_pv;
  logic last_k;
  logic hit;
  logic tgt_ok;
  logic over_budget;
  logic act_v;

  assign accept      = in_valid_i && in_ready_o;
  assign room        = held_cnt_q < HCW'(HELD_NOTES);
  assign last_v      = v_q == VIW'(VOICES - 1);
  assign last_pv     = pv_q == VIW'(VOICES - 1);
  assign last_k      = HCW'(k_q) == held_cnt_q - HCW'(1);
  assign hit         = pvld_q && (slot_st_q[pv_q] == SlotSustain) &&
                       (vmem_rdata_q.note == hmem_rdata_q);
  assign tgt_ok      = {{VIW{1'b0}}, target_voice_i} < (VIW + TgtW)'(VOICES);
  assign over_budget = CmpW'(act_cnt_q) > CmpW'(budget_q);
  assign act_v       = slot_st_q[v_q] != SlotInactive;

  always_comb begin
    vmem_re    = 1'b0;
    vmem_raddr = v_q;
    vmem_we    = 1'b0;
    vmem_waddr = v_q;
    vmem_wdata = '{note: vmem_rdata_q.note, det: dt_rsp.offset};
    hmem_re    = 1'b0;
    hmem_we    = 1'b0;
    case (state_q)
      StIdle: begin
        hmem_we = accept && (mode_e'(mode_i) == ModeHeld) && room;
      end
      StS1Hrd, StS3Hrd: begin
        hmem_re = 1'b1;
      end
      StS1Scan, StS3Scan: begin
        vmem_re = !iss_done_q;
      end
      StS3Alloc: begin
        vmem_we    = !found_q && (pick_i_vld_q || pick_f_vld_q);
        vmem_waddr = pick_i_vld_q ? pick_i_q : pick_f_q;
        vmem_wdata = '{note: hmem_rdata_q, det: '0};
      end
      StEmRd: begin
        vmem_re = 1'b1;
      end
      StEmDt: begin
        vmem_we = dt_rsp.done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      for (int i = 0; i < VOICES; i++) begin
        slot_st_q[i] <= SlotInactive;
      end
      matched_q    <= '0;
      sus1_q       <= '0;
      held_cnt_q   <= '0;
      k_q          <= '0;
      v_q          <= '0;
      iss_done_q   <= 1'b0;
      pvld_q       <= 1'b0;
      pv_q         <= '0;
      found_q      <= 1'b0;
      pick_i_vld_q <= 1'b0;
      pick_i_q     <= '0;
      pick_f_vld_q <= 1'b0;
      pick_f_q     <= '0;
      ncnt_q       <= '0;
      rank_q       <= '0;
      act_cnt_q    <= '0;
      det_q        <= '0;
      out_valid_q  <= 1'b0;
      out_slot_q   <= '0;
      out_state_q  <= '0;
      out_note_q   <= '0;
      out_det_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // the record state loads its own valid
      if (out_valid_q && out_ready_i && state_q != StEmOut) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (mode_e'(mode_i))
              ModeHeld: begin
                if (room) begin
                  held_cnt_q <= held_cnt_q + HCW'(1);
                end
                if (last_note_i) begin
                  k_q       <= '0;
                  v_q       <= '0;
                  matched_q <= '0;
                  ncnt_q    <= '0;
                  state_q   <= StS1Hrd;
                end
              end
              ModeEmpty: begin
                held_cnt_q <= '0;
                v_q        <= '0;
                matched_q  <= '0;
                ncnt_q     <= '0;
                state_q    <= StS1Apply;
              end
              ModeFade: begin
                if (tgt_ok && slot_st_q[VIW'(target_voice_i)] == SlotFading) begin
                  slot_st_q[VIW'(target_voice_i)] <= SlotInactive;
                  act_cnt_q <= act_cnt_q - CW'(1);
                end
              end
              ModeBudget: begin
                v_q     <= '0;
                state_q <= StBudget;
              end
              default: ;
            endcase
          end
        end

        // release pass marks voices whose note is still listed; the allocation pass shares these states
        StS1Hrd, StS3Hrd: begin
          v_q          <= '0;
          iss_done_q   <= 1'b0;
          pvld_q       <= 1'b0;
          found_q      <= 1'b0;
          pick_i_vld_q <= 1'b0;
          pick_f_vld_q <= 1'b0;
          state_q      <= (state_q == StS1Hrd) ? StS1Scan : StS3Scan;
        end

        StS1Scan, StS3Scan: begin
          pvld_q <= !iss_done_q;
          pv_q   <= v_q;
          if (!iss_done_q) begin
            if (last_v) begin
              iss_done_q <= 1'b1;
            end else begin
              v_q <= v_q + VIW'(1);
            end
          end
          if (state_q == StS1Scan) begin
            if (hit) begin
              matched_q[pv_q] <= 1'b1;
            end
          end else begin
            if (hit) begin
              found_q <= 1'b1;
            end
            if (pvld_q && slot_st_q[pv_q] == SlotInactive && !pick_i_vld_q) begin
              pick_i_vld_q <= 1'b1;
              pick_i_q     <= pv_q;
            end
            if (pvld_q && slot_st_q[pv_q] == SlotFading && !pick_f_vld_q) begin
              pick_f_vld_q <= 1'b1;
              pick_f_q     <= pv_q;
            end
          end
          if (pvld_q && last_pv) begin
            if (state_q == StS1Scan) begin
              if (last_k) begin
                v_q     <= '0;
                state_q <= StS1Apply;
              end else begin
                k_q     <= k_q + HIW'(1);
                state_q <= StS1Hrd;
              end
            end else begin
              state_q <= StS3Alloc;
            end
          end
        end

        StS1Apply: begin
          sus1_q[v_q] <= (slot_st_q[v_q] == SlotSustain) && matched_q[v_q];
          if (slot_st_q[v_q] == SlotSustain) begin
            if (matched_q[v_q]) begin
              ncnt_q <= ncnt_q + CW'(1);
            end else begin
              slot_st_q[v_q] <= SlotFading;
            end
          end
          if (last_v) begin
            k_q <= '0;
            v_q <= '0;
            if (held_cnt_q == '0) begin
              rank_q  <= '0;
              state_q <= StEmRd;
            end else begin
              state_q <= StS3Hrd;
            end
          end else begin
            v_q <= v_q + VIW'(1);
          end
        end

        // allocate a voice to a listed note that has none
        StS3Alloc: begin
          if (!found_q) begin
            if (pick_i_vld_q) begin
              slot_st_q[pick_i_q] <= SlotSustain;
              act_cnt_q           <= act_cnt_q + CW'(1);
            end else if (pick_f_vld_q) begin
              slot_st_q[pick_f_q] <= SlotSustain;
            end
          end
          if (last_k) begin
            held_cnt_q <= '0;
            v_q        <= '0;
            rank_q     <= '0;
            state_q    <= StEmRd;
          end else begin
            k_q     <= k_q + HIW'(1);
            state_q <= StS3Hrd;
          end
        end

        StEmRd: begin
          held_cnt_q <= '0;
          state_q    <= StEmChk;
        end

        StEmChk: begin
          if (sus1_q[v_q]) begin
            state_q <= StEmDt;
          end else begin
            det_q   <= vmem_rdata_q.det;
            state_q <= StEmOut;
          end
        end

        StEmDt: begin
          if (dt_rsp.done) begin
            det_q   <= dt_rsp.offset;
            rank_q  <= rank_q + VIW'(1);
            state_q <= StEmOut;
          end
        end

        StEmOut: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_slot_q  <= SlotW'(v_q);
            out_state_q <= slot_st_q[v_q];
            out_note_q  <= act_v ? vmem_rdata_q.note : '0;
            out_det_q   <= act_v ? det_q : '0;
            out_last_q  <= last_v;
            if (last_v) begin
              state_q <= StIdle;
            end else begin
              v_q     <= v_q + VIW'(1);
              state_q <= StEmRd;
            end
          end
        end

        // kill fading voices in index order while over budget
        StBudget: begin
          if (over_budget && slot_st_q[v_q] == SlotFading) begin
            slot_st_q[v_q] <= SlotInactive;
            act_cnt_q      <= act_cnt_q - CW'(1);
          end
          if (last_v) begin
            state_q <= StIdle;
          end else begin
            v_q <= v_q + VIW'(1);
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = out_valid_q;
  assign voice_slot_o    = out_slot_q;
  assign slot_state_o    = out_state_q;
  assign slot_note_o     = out_note_q;
  assign detune_offset_o = signed'(out_det_q);
  assign last_record_o   = out_last_q;

endmodule

### sv/pva_checker.sv
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pva_checker
  import pva_pkg::*;
#(
  parameter int unsigned VOICES = DefVoices
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [ModeW-1:0]       mode_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SlotW-1:0]       voice_slot_o,
  input logic [StateW-1:0]      slot_state_o,
  input logic [NoteW-1:0]       slot_note_o,
  input logic signed [DetW-1:0] detune_offset_o,
  input logic                   last_record_o
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(voice_slot_o) &&
    $stable(slot_state_o) && $stable(slot_note_o) && $stable(detune_offset_o) &&
    $stable(last_record_o))
    else $error("output record changed while stalled");

  // an empty-list transfer starts a run, so input is held off next cycle
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == ModeEmpty |=> !in_ready_o)
    else $error("input taken during allocation run");

  // the final record belongs to the highest voice
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_record_o |-> voice_slot_o == SlotW'(VOICES - 1))
    else $error("last record on wrong voice");

  // inactive voices report no note and no detune
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_state_o == SlotInactive |->
    slot_note_o == '0 && detune_offset_o == '0)
    else $error("inactive voice with note or detune");

endmodule

bind polyphonic_voice_allocator pva_checker #(.VOICES(VOICES)) u_pva_checker (.*);
